[rtl/core/wdkbm_pkg.sv]
// ----------------------------------------------------------------------------
// Watchdog kick and battery monitor package
// Request opcodes, configuration register indexes and field widths shared by
// the supervisor logic.
// ----------------------------------------------------------------------------
package wdkbm_pkg;

  // Request opcodes
  typedef enum logic [2:0] {
    OpTick   = 3'd0,
    OpStart  = 3'd1,
    OpAlive  = 3'd2,
    OpReboot = 3'd3,
    OpRead   = 3'd4
  } op_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgRefreshPeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSamplePeriod  = 1'b1;

  // Field widths
  localparam int unsigned PeriodW = 16;
  localparam int unsigned VoltW   = 10;
  localparam int unsigned AvgW    = 18;
  localparam int unsigned FracW   = 8;
  localparam int unsigned RidxW   = 7;
  localparam int unsigned TaskW   = 2;
  localparam int unsigned CountW  = 7;
  localparam int unsigned NumTask = 3;

  // Period reset values
  localparam logic [PeriodW-1:0] RefreshPeriodRst = 16'd200;
  localparam logic [PeriodW-1:0] SamplePeriodRst  = 16'd2000;

endpackage

[rtl/core/watchdog_kick_and_battery_monitor.sv]
// ----------------------------------------------------------------------------
// Watchdog kick and battery monitor
// A request passes through the input register, then the result register with
// the history read port. Throughput: one request per cycle unless the result
// side stalls; the history memory is read and written at most once per cycle.
// Reset clears all counters, flags, the average and the ring pointers at once;
// the history memory itself is not cleared.
// ----------------------------------------------------------------------------
module watchdog_kick_and_battery_monitor
  import wdkbm_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH  = 128,
  parameter int unsigned AVERAGE_WINDOW = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [PeriodW-1:0]  cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          op_i,
  input  logic [TaskW-1:0]    task_id_i,
  input  logic [VoltW-1:0]    voltage_i,
  input  logic [RidxW-1:0]    read_index_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                refresh_pulse_o,
  output logic                adc_request_o,
  output logic                sample_taken_o,
  output logic [VoltW-1:0]    last_voltage_o,
  output logic [AvgW-1:0]     average_voltage_o,
  output logic [CountW-1:0]   history_count_o,
  output logic                history_valid_o,
  output logic [VoltW-1:0]    history_value_o
);

  // Ring geometry
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned PW = ((AW > RidxW) ? AW : RidxW) + 2;
  localparam logic [AW-1:0] HeadLast = AW'(HISTORY_DEPTH - 1);
  localparam logic [PW-1:0] DepthP   = PW'(HISTORY_DEPTH);

  // Constant divide by the window: floor(n / W) = (n * DivM) >> DivS for n < 2^AvgW + W
  localparam int unsigned DivK  = AvgW + 1;
  localparam int unsigned DivS  = DivK + $clog2(AVERAGE_WINDOW);
  localparam int unsigned MW    = DivK + 2;
  localparam longint unsigned DivMFull =
    ((longint'(1) << DivS) + AVERAGE_WINDOW - 1) / AVERAGE_WINDOW;
  localparam logic [MW-1:0] DivM   = DivMFull[MW-1:0];
  localparam logic [DivK-1:0] WinM1 = DivK'(AVERAGE_WINDOW - 1);

  // Configuration registers
  logic [PeriodW-1:0] refresh_period_q, sample_period_q;

  // Supervisor state
  logic [PeriodW-1:0] refresh_count_q, refresh_count_d;
  logic [PeriodW-1:0] sample_count_q, sample_count_d;
  logic [NumTask-1:0] alive_flags_q, alive_flags_d;
  logic               reboot_pending_q, reboot_pending_d;
  logic [VoltW-1:0]   kept_voltage_q, kept_voltage_d;
  logic [AvgW-1:0]    average_acc_q, average_acc_d;
  logic [AW-1:0]      ring_head_q, ring_head_d;
  logic [AW-1:0]      ring_fill_q, ring_fill_d;

  // Input register
  logic               s1_valid_q;
  logic [2:0]         s1_op_q;
  logic [TaskW-1:0]   s1_task_q;
  logic [VoltW-1:0]   s1_volt_q;
  logic [RidxW-1:0]   s1_ridx_q;

  // Result register
  logic               out_valid_q;
  logic               pulse_q, adc_q, taken_q, hvalid_q;
  logic [VoltW-1:0]   last_volt_q;
  logic [AvgW-1:0]    avg_q;
  logic [CountW-1:0]  count_q;
  logic [VoltW-1:0]   rd_q;

  // History memory
  logic [VoltW-1:0]   mem_q [HISTORY_DEPTH];

  // Handshake
  logic out_ready, s1_fire, in_load;

  // Per-request results
  logic pulse, adc, taken, hvalid;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;

  // Average datapath
  logic [AvgW-1:0]      volt_fx;
  logic                 avg_neg;
  logic [AvgW-1:0]      avg_mag;
  logic [DivK-1:0]      div_n;
  logic [DivK+MW-1:0]   div_prod;
  logic [AvgW:0]        div_q;
  logic [AvgW-1:0]      avg_next;

  // Ring read address
  logic [PW-1:0] pos_sum, pos_wrap;
  logic          idx_ok;

  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign s1_fire    = s1_valid_q & out_ready;
  assign in_stall_o = s1_valid_q & ~out_ready;
  assign in_load    = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_period_q <= RefreshPeriodRst;
      sample_period_q  <= SamplePeriodRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgRefreshPeriod) begin
        refresh_period_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgSamplePeriod) begin
        sample_period_q <= cfg_data_i;
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_op_q   <= op_i;
      s1_task_q <= task_id_i;
      s1_volt_q <= voltage_i;
      s1_ridx_q <= read_index_i;
    end
  end

  // Moving average step: avg + floor((v<<8 - avg) / W)
  assign volt_fx  = {s1_volt_q, {FracW{1'b0}}};
  assign avg_neg  = volt_fx < average_acc_q;
  assign avg_mag  = avg_neg ? (average_acc_q - volt_fx) : (volt_fx - average_acc_q);
  assign div_n    = {1'b0, avg_mag} + (avg_neg ? WinM1 : '0);
  assign div_prod = (DivK+MW)'(div_n) * (DivK+MW)'(DivM);
  assign div_q    = (AvgW+1)'(div_prod[DivK+MW-1:DivS]);
  assign avg_next = avg_neg ? AvgW'({1'b0, average_acc_q} - div_q)
                            : AvgW'({1'b0, average_acc_q} + div_q);

  // Locate the requested history entry
  assign idx_ok   = PW'(s1_ridx_q) < PW'(ring_fill_q);
  assign pos_sum  = PW'(ring_head_q) + DepthP - PW'(ring_fill_q) + PW'(s1_ridx_q);
  assign pos_wrap = (pos_sum >= DepthP) ? (pos_sum - DepthP) : pos_sum;
  assign mem_raddr = pos_wrap[AW-1:0];

  // Work out the next state and result for the request in the input register
  always_comb begin
    refresh_count_d  = refresh_count_q;
    sample_count_d   = sample_count_q;
    alive_flags_d    = alive_flags_q;
    reboot_pending_d = reboot_pending_q;
    kept_voltage_d   = kept_voltage_q;
    average_acc_d    = average_acc_q;
    ring_head_d      = ring_head_q;
    ring_fill_d      = ring_fill_q;
    pulse            = 1'b0;
    adc              = 1'b0;
    taken            = 1'b0;
    hvalid           = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = ring_head_q;

    unique case (op_e'(s1_op_q))
      OpTick: begin
        adc = 1'b1;
        refresh_count_d = PeriodW'(refresh_count_q + 16'd1);
        if (refresh_count_d >= refresh_period_q) begin
          pulse = (&alive_flags_q) & ~reboot_pending_q;
          alive_flags_d   = '0;
          refresh_count_d = '0;
        end
        sample_count_d = PeriodW'(sample_count_q + 16'd1);
        if (sample_count_d >= sample_period_q) begin
          taken          = 1'b1;
          mem_we         = 1'b1;
          ring_head_d    = (ring_head_q == HeadLast) ? '0 : AW'(ring_head_q + 1'b1);
          ring_fill_d    = (ring_fill_q == HeadLast) ? ring_fill_q
                                                     : AW'(ring_fill_q + 1'b1);
          sample_count_d = '0;
          if (s1_volt_q != kept_voltage_q) begin
            kept_voltage_d = s1_volt_q;
            average_acc_d  = avg_next;
          end
        end
      end
      OpStart: begin
        refresh_count_d = '0;
        sample_count_d  = '0;
        alive_flags_d   = '0;
        kept_voltage_d  = s1_volt_q;
        average_acc_d   = volt_fx;
        // Empty the ring and store the first sample in slot zero
        mem_we      = 1'b1;
        mem_waddr   = '0;
        ring_head_d = AW'(1);
        ring_fill_d = AW'(1);
        taken       = 1'b1;
      end
      OpAlive: begin
        if (s1_task_q < TaskW'(NumTask)) begin
          alive_flags_d[s1_task_q] = 1'b1;
        end
      end
      OpReboot: begin
        reboot_pending_d = 1'b1;
      end
      OpRead: begin
        hvalid = idx_ok;
      end
      default: begin
      end
    endcase
  end

  // Advance the supervisor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_count_q  <= '0;
      sample_count_q   <= '0;
      alive_flags_q    <= '0;
      reboot_pending_q <= 1'b0;
      kept_voltage_q   <= '0;
      average_acc_q    <= '0;
      ring_head_q      <= '0;
      ring_fill_q      <= '0;
    end else if (s1_fire) begin
      refresh_count_q  <= refresh_count_d;
      sample_count_q   <= sample_count_d;
      alive_flags_q    <= alive_flags_d;
      reboot_pending_q <= reboot_pending_d;
      kept_voltage_q   <= kept_voltage_d;
      average_acc_q    <= average_acc_d;
      ring_head_q      <= ring_head_d;
      ring_fill_q      <= ring_fill_d;
    end
  end

  // History memory: at most one write and one registered read per cycle, on an accepted request
  always_ff @(posedge clk_i) begin
    if (s1_fire && mem_we) begin
      mem_q[mem_waddr] <= s1_volt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pulse_q     <= pulse;
      adc_q       <= adc;
      taken_q     <= taken;
      hvalid_q    <= hvalid;
      last_volt_q <= kept_voltage_d;
      avg_q       <= average_acc_d;
      count_q     <= CountW'(ring_fill_d);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign refresh_pulse_o   = pulse_q;
  assign adc_request_o     = adc_q;
  assign sample_taken_o    = taken_q;
  assign last_voltage_o    = last_volt_q;
  assign average_voltage_o = avg_q;
  assign history_count_o   = count_q;
  assign history_valid_o   = hvalid_q;
  assign history_value_o   = hvalid_q ? rd_q : '0;

endmodule

[tb/tb_watchdog_kick_and_battery_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Watchdog kick and battery monitor testbench
// Streams tick, start, alive, reboot, history-read and unused-opcode requests
// into the block, mostly under random valid gaps and result stalls. A local
// model of the supervisor predicts every result; each is checked field by
// field in order. Period registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_watchdog_kick_and_battery_monitor;
  import wdkbm_pkg::*;

  localparam int unsigned HistDepth  = 128;
  localparam int unsigned AvgWindow  = 60;
  localparam int unsigned IdlePct    = 32;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;
  // opcodes outside the defined set, and the task number that is ignored
  localparam logic [2:0]       OpUnusedFirst = 3'd5;
  localparam logic [2:0]       OpUnusedLast  = 3'd7;
  localparam logic [TaskW-1:0] TaskNone      = 2'd3;

  typedef struct packed {
    logic [2:0]       op;
    logic [TaskW-1:0] tid;
    logic [VoltW-1:0] voltage;
    logic [RidxW-1:0] read_index;
  } request_t;

  typedef struct packed {
    logic              refresh_pulse;
    logic              adc_request;
    logic              sample_taken;
    logic [VoltW-1:0]  last_voltage;
    logic [AvgW-1:0]   average_voltage;
    logic [CountW-1:0] history_count;
    logic              history_valid;
    logic [VoltW-1:0]  history_value;
  } status_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = CfgRefreshPeriod;
  logic [PeriodW-1:0]  cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [2:0]          op_i         = OpTick;
  logic [TaskW-1:0]    task_id_i    = '0;
  logic [VoltW-1:0]    voltage_i    = '0;
  logic [RidxW-1:0]    read_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                refresh_pulse_o;
  logic                adc_request_o;
  logic                sample_taken_o;
  logic [VoltW-1:0]    last_voltage_o;
  logic [AvgW-1:0]     average_voltage_o;
  logic [CountW-1:0]   history_count_o;
  logic                history_valid_o;
  logic [VoltW-1:0]    history_value_o;

  watchdog_kick_and_battery_monitor u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .task_id_i        (task_id_i),
    .voltage_i        (voltage_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .refresh_pulse_o  (refresh_pulse_o),
    .adc_request_o    (adc_request_o),
    .sample_taken_o   (sample_taken_o),
    .last_voltage_o   (last_voltage_o),
    .average_voltage_o(average_voltage_o),
    .history_count_o  (history_count_o),
    .history_valid_o  (history_valid_o),
    .history_value_o  (history_value_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Supervisor model state
  logic [PeriodW-1:0] period_refresh = RefreshPeriodRst;
  logic [PeriodW-1:0] period_sample  = SamplePeriodRst;
  logic [PeriodW-1:0] refresh_ticks  = '0;
  logic [PeriodW-1:0] sample_ticks   = '0;
  logic [NumTask-1:0] alive_seen     = '0;
  logic               reboot_latched = 1'b0;
  logic [VoltW-1:0]   kept_volt      = '0;
  logic [AvgW-1:0]    avg_fix        = '0;
  logic [VoltW-1:0]   ring_mem [HistDepth];
  logic [CountW-1:0]  ring_wr        = '0;
  logic [CountW-1:0]  ring_len       = '0;

  // Stimulus and scoreboard bookkeeping
  request_t    pending_reqs [$];
  status_t     status_q [$];
  int unsigned inflight   = 0;
  int unsigned queued     = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_cnt  = 0;
  logic        req_taken  = 1'b0;
  logic        no_idle    = 1'b0;
  logic [VoltW-1:0] gen_volt = '0;

  // Store a sample in the ring, dropping the oldest once it is full
  function automatic void ring_store(logic [VoltW-1:0] v);
    ring_mem[ring_wr] = v;
    ring_wr = ring_wr + 1'b1;
    if (ring_len < CountW'(HistDepth - 1)) ring_len = ring_len + 1'b1;
  endfunction

  // Advance the supervisor by one request and return the status it reports
  function automatic status_t step_supervisor(request_t req);
    status_t          res;
    logic [31:0]      acc;
    logic [CountW-1:0] pos;
    res = '0;
    case (req.op)
      OpTick: begin
        refresh_ticks = refresh_ticks + 1'b1;
        if (refresh_ticks >= period_refresh) begin
          res.refresh_pulse = (&alive_seen) && !reboot_latched;
          alive_seen = '0;
          refresh_ticks = '0;
        end
        sample_ticks = sample_ticks + 1'b1;
        if (sample_ticks >= period_sample) begin
          ring_store(req.voltage);
          res.sample_taken = 1'b1;
          // only a changed sample moves the average
          if (req.voltage != kept_volt) begin
            kept_volt = req.voltage;
            acc = 32'(avg_fix) * (AvgWindow - 1) + (32'(req.voltage) << FracW);
            avg_fix = AvgW'(acc / AvgWindow);
          end
          sample_ticks = '0;
        end
        res.adc_request = 1'b1;
      end
      OpStart: begin
        refresh_ticks = '0;
        sample_ticks = '0;
        alive_seen = '0;
        kept_volt = req.voltage;
        avg_fix = {req.voltage, {FracW{1'b0}}};
        ring_wr = '0;
        ring_len = '0;
        ring_store(req.voltage);
        res.sample_taken = 1'b1;
      end
      OpAlive: begin
        if (req.tid != TaskNone) alive_seen[req.tid] = 1'b1;
      end
      OpReboot: begin
        reboot_latched = 1'b1;
      end
      OpRead: begin
        if (CountW'(req.read_index) < ring_len) begin
          pos = ring_wr - ring_len + CountW'(req.read_index);
          res.history_valid = 1'b1;
          res.history_value = ring_mem[pos];
        end
      end
      default: begin
      end
    endcase
    res.last_voltage = kept_volt;
    res.average_voltage = avg_fix;
    res.history_count = ring_len;
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Drive requests at the falling edge; hold a request until it is taken
  always @(negedge clk_i) begin : drive_requests
    request_t req;
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (pending_reqs.size() != 0 && (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
          req = pending_reqs.pop_front();
          op_i         <= req.op;
          task_id_i    <= req.tid;
          voltage_i    <= req.voltage;
          read_index_i <= req.read_index;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin : watch_results
    request_t req;
    status_t  want;
    req_taken = rst_ni && in_valid_i && !in_stall_o;
    if (req_taken) begin
      req.op         = op_i;
      req.tid        = task_id_i;
      req.voltage    = voltage_i;
      req.read_index = read_index_i;
      status_q.push_back(step_supervisor(req));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_count++;
      end else begin
        want = status_q.pop_front();
        inflight--;
        check_field("refresh_pulse", want.refresh_pulse, refresh_pulse_o);
        check_field("adc_request", want.adc_request, adc_request_o);
        check_field("sample_taken", want.sample_taken, sample_taken_o);
        check_field("last_voltage", want.last_voltage, last_voltage_o);
        check_field("average_voltage", want.average_voltage, average_voltage_o);
        check_field("history_count", want.history_count, history_count_o);
        check_field("history_valid", want.history_valid, history_valid_o);
        check_field("history_value", want.history_value, history_value_o);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin : count_cycles
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_watchdog_kick_and_battery_monitor failed");
      $finish;
    end
  end

  task automatic add_item(logic [2:0] op, logic [TaskW-1:0] tid, logic [VoltW-1:0] v,
                          logic [RidxW-1:0] ridx);
    request_t req;
    req.op = op;
    req.tid = tid;
    req.voltage = v;
    req.read_index = ridx;
    pending_reqs.push_back(req);
    inflight++;
    queued++;
  endtask

  // Repeat the previous voltage often so unchanged samples occur
  function automatic logic [VoltW-1:0] next_volt();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) gen_volt = '0;
    else if (roll < 20) gen_volt = '1;
    else if (roll < 50) gen_volt = VoltW'($urandom_range(0, 1023));
    return gen_volt;
  endfunction

  // Mostly near the oldest entries, some near the ring end
  function automatic logic [RidxW-1:0] next_index();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return RidxW'($urandom_range(0, 20));
    if (roll < 75) return RidxW'($urandom_range(120, 127));
    return RidxW'($urandom_range(0, 127));
  endfunction

  function automatic logic [TaskW-1:0] any_task();
    return TaskW'($urandom_range(0, 3));
  endfunction

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [PeriodW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgRefreshPeriod) period_refresh = val;
    else period_sample = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold off until every queued request has produced its result
  task automatic wait_drained();
    while (inflight != 0) @(negedge clk_i);
  endtask

  // Queue random traffic: mostly alive rounds followed by ticks, plus noise
  task automatic queue_random(int unsigned count, bit with_start, bit with_reboot);
    int unsigned goal;
    int unsigned roll;
    int unsigned first;
    int unsigned skip;
    goal = queued + count;
    while (queued < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        first = $urandom_range(0, NumTask - 1);
        skip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NumTask - 1) : NumTask;
        for (int k = 0; k < NumTask; k++) begin
          if ((first + k) % NumTask != skip)
            add_item(OpAlive, TaskW'((first + k) % NumTask), next_volt(), next_index());
        end
        repeat ($urandom_range(1, 4)) begin
          add_item(OpTick, any_task(), next_volt(), next_index());
          if ($urandom_range(0, 3) == 0) add_item(OpRead, any_task(), next_volt(), next_index());
        end
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 30) add_item(OpTick, any_task(), next_volt(), next_index());
        else if (roll < 55) add_item(OpRead, any_task(), next_volt(), next_index());
        else if (roll < 68) add_item(OpAlive, any_task(), next_volt(), next_index());
        else if (roll < 78)
          add_item(3'($urandom_range(OpUnusedFirst, OpUnusedLast)), any_task(), next_volt(),
                   next_index());
        else if (roll < 86 && with_start)
          add_item(OpStart, any_task(), next_volt(), next_index());
        else if (roll < 89 && with_reboot)
          add_item(OpReboot, any_task(), next_volt(), next_index());
        else add_item(OpTick, any_task(), next_volt(), next_index());
      end
    end
  endtask

  task automatic set_periods(logic [PeriodW-1:0] refresh, logic [PeriodW-1:0] sample);
    write_cfg(CfgRefreshPeriod, refresh);
    write_cfg(CfgSamplePeriod, sample);
  endtask

  initial begin : run_sequence
    // hold reset low, then release it at a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset periods: empty-ring reads, unused ops, ignored task, a tick, both starts
    add_item(OpRead, '0, '0, '0);
    add_item(OpRead, '0, '0, '1);
    add_item(OpUnusedFirst, '1, '1, '1);
    add_item(3'(OpUnusedFirst + 1), '0, '0, '0);
    add_item(OpUnusedLast, '1, '1, '1);
    add_item(OpAlive, TaskNone, '0, '0);
    add_item(OpTick, '1, '1, '1);
    add_item(OpStart, '0, '0, '0);
    add_item(OpRead, '0, '0, '0);
    add_item(OpRead, '0, '0, RidxW'(1));
    add_item(OpStart, '0, '1, '0);
    add_item(OpRead, '0, '0, '0);
    wait_drained();

    // Shortest periods: refresh on all-alive, unchanged and changed samples
    set_periods(PeriodW'(1), PeriodW'(1));
    add_item(OpAlive, TaskW'(0), '0, '0);
    add_item(OpAlive, TaskW'(1), '0, '0);
    add_item(OpAlive, TaskW'(2), '0, '0);
    add_item(OpTick, '0, '1, '0);
    add_item(OpTick, '0, '0, '0);
    add_item(OpTick, '0, '0, '0);
    add_item(OpAlive, TaskW'(2), '0, '0);
    add_item(OpAlive, TaskW'(1), '0, '0);
    add_item(OpTick, '0, VoltW'(512), '0);
    add_item(OpRead, '0, '0, '0);
    add_item(OpRead, '0, '0, RidxW'(3));
    add_item(OpRead, '0, '0, RidxW'(4));
    add_item(OpRead, '0, '0, '1);
    wait_drained();

    // No starts here so the ring fills and wraps
    queue_random(380, 1'b0, 1'b0);
    wait_drained();

    set_periods(PeriodW'(2), PeriodW'(3));
    queue_random(260, 1'b1, 1'b0);
    wait_drained();

    set_periods('1, '1);
    queue_random(100, 1'b1, 1'b0);
    wait_drained();

    // Back-to-back traffic with no gaps or stalls
    no_idle = 1'b1;
    set_periods(PeriodW'($urandom_range(1, 8)), PeriodW'($urandom_range(1, 6)));
    queue_random(300, 1'b1, 1'b0);
    wait_drained();
    no_idle = 1'b0;

    set_periods(PeriodW'(4), PeriodW'(1));
    queue_random(330, 1'b1, 1'b0);
    wait_drained();

    // Reboot is sticky until reset, so it only appears in the last phase
    set_periods(PeriodW'(1), PeriodW'(2));
    add_item(OpReboot, '0, '0, '0);
    add_item(OpAlive, TaskW'(0), '0, '0);
    add_item(OpAlive, TaskW'(1), '0, '0);
    add_item(OpAlive, TaskW'(2), '0, '0);
    add_item(OpTick, '0, '1, '0);
    queue_random(180, 1'b1, 1'b1);
    wait_drained();

    repeat (DrainWait) @(negedge clk_i);
    if (status_q.size() != 0) begin
      $error("%0d results never arrived", status_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_watchdog_kick_and_battery_monitor passed");
    end else begin
      $display("tb_watchdog_kick_and_battery_monitor failed");
    end
    $finish;
  end

endmodule
